### rtl/cpg_pkg.sv
// ============================================================================
// cpg_pkg - shared types and constants of the circle point generator
// Field widths, item codes and the step job handed from front to back.
// ============================================================================
package cpg_pkg;

    localparam int unsigned COORD_W    = 8;   // centre, radius, point fields
    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned WALK_W     = 10;  // signed walk coordinates
    localparam int unsigned DEC_W      = 14;  // signed decision variable
    localparam int unsigned POINTS     = 8;   // points per step
    localparam int unsigned IDX_W      = $clog2(POINTS);
    localparam int unsigned S_DATA_W   = 40;  // 33 payload bits padded to bytes
    localparam int unsigned M_DATA_W   = 24;
    localparam int unsigned QUEUE_DEPTH = 2;

    // item codes on the input tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // one step worth of work: eight symmetric points of the pair (a, b)
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic               done;
    } job_t;

    // push side of the job queue
    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

endpackage

### rtl/cpg_front.sv
// ============================================================================
// cpg_front - item intake and midpoint walk
// Decodes start and step items, advances the walk and pushes step jobs.
// ============================================================================
module cpg_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_fire,
    input  logic                        item_mode,
    input  logic [cpg_pkg::COORD_W-1:0] item_cx,
    input  logic [cpg_pkg::COORD_W-1:0] item_cy,
    input  logic [cpg_pkg::COORD_W-1:0] item_radius,
    input  logic                        item_fill,
    input  logic [cpg_pkg::COLOR_W-1:0] item_color,
    output cpg_pkg::job_push_t          push
);
    import cpg_pkg::*;

    logic                        busy_reg, busy_next;
    logic [COORD_W-1:0]          cx_reg, cx_next;
    logic [COORD_W-1:0]          cy_reg, cy_next;
    logic [COLOR_W-1:0]          color_reg, color_next;
    logic                        fill_reg, fill_next;
    logic signed [WALK_W-1:0]    x_reg, x_next;
    logic signed [WALK_W-1:0]    y_reg, y_next;
    logic signed [WALK_W-1:0]    span_reg, span_next;
    logic signed [DEC_W-1:0]     dec_reg, dec_next;

    // walk advance, computed from the current state
    logic signed [WALK_W-1:0]    adv_x, adv_y, span_inc;
    logic signed [DEC_W-1:0]     adv_dec, x_ext, diff_ext;

    always_comb
    begin
        x_ext    = DEC_W'(x_reg);
        diff_ext = DEC_W'(x_reg) - DEC_W'(y_reg);
        adv_x    = x_reg + WALK_W'(1);
        if (dec_reg < 0)
        begin
            adv_dec = dec_reg + (x_ext <<< 2) + DEC_W'(6);
            adv_y   = y_reg;
        end
        else
        begin
            adv_dec = dec_reg + (diff_ext <<< 2) + DEC_W'(10);
            adv_y   = y_reg - WALK_W'(1);
        end
        span_inc = span_reg + WALK_W'(1);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        fill_next  = fill_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        span_next  = span_reg;
        dec_next   = dec_reg;
        push.valid = 1'b0;
        push.job.cx    = cx_reg;
        push.job.cy    = cy_reg;
        push.job.color = color_reg;
        push.job.a     = x_reg[COORD_W-1:0];
        push.job.b     = fill_reg ? span_reg[COORD_W-1:0] : y_reg[COORD_W-1:0];
        push.job.done  = 1'b0;

        if (item_fire && item_mode == MODE_START)
        begin
            cx_next    = item_cx;
            cy_next    = item_cy;
            fill_next  = item_fill;
            color_next = item_color;
            x_next     = '0;
            y_next     = WALK_W'(item_radius);
            span_next  = '0;
            dec_next   = DEC_W'(3) - (DEC_W'(item_radius) <<< 1);
            busy_next  = 1'b1;
        end
        else if (item_fire && busy_reg)
        begin
            push.valid = 1'b1;
            if (fill_reg)
            begin
                // next row of the span; walk moves on after its last row
                if (span_inc > y_reg)
                begin
                    x_next    = adv_x;
                    y_next    = adv_y;
                    dec_next  = adv_dec;
                    span_next = adv_x;
                end
                else
                begin
                    span_next = span_inc;
                end
            end
            else
            begin
                x_next   = adv_x;
                y_next   = adv_y;
                dec_next = adv_dec;
            end
            push.job.done = (x_next > y_next);
            if (x_next > y_next)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
            fill_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            span_reg  <= '0;
            dec_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
            fill_reg  <= fill_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            span_reg  <= span_next;
            dec_reg   <= dec_next;
        end
    end

endmodule

### rtl/cpg_queue.sv
// ============================================================================
// cpg_queue - short job queue
// Two-entry FIFO between the walk front end and the point emitter.
// ============================================================================
module cpg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  cpg_pkg::job_push_t push,
    output logic               push_ready,
    output logic               pop_valid,
    output cpg_pkg::job_t      pop_job,
    input  logic               pop
);
    import cpg_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push.valid && push_ready;
        do_pop      = pop && pop_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/cpg_back.sv
// ============================================================================
// cpg_back - point emitter
// Expands one step job into eight symmetric points, one per cycle while the output is not stalled.
// ============================================================================
module cpg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  cpg_pkg::job_t               job,
    output logic                        job_pop,
    output logic                        pt_valid,
    input  logic                        pt_ready,
    output logic [cpg_pkg::COORD_W-1:0] pt_x,
    output logic [cpg_pkg::COORD_W-1:0] pt_y,
    output logic [cpg_pkg::COLOR_W-1:0] pt_color,
    output logic                        pt_last,
    output logic                        pt_done
);
    import cpg_pkg::*;

    job_t                 cur_reg;
    logic                 cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   x_reg, y_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic                 last_reg, done_reg;

    logic                 load, take, last_pt;
    logic [COORD_W-1:0]   u, v, px, py;

    always_comb
    begin
        load    = !out_valid_reg || pt_ready;
        take    = load && cur_valid_reg;
        last_pt = (idx_reg == IDX_W'(POINTS - 1));
        job_pop = job_valid && (!cur_valid_reg || (take && last_pt));

        // bit 2 swaps the pair, bit 0 mirrors columns, bit 1 mirrors rows
        u  = idx_reg[2] ? cur_reg.b : cur_reg.a;
        v  = idx_reg[2] ? cur_reg.a : cur_reg.b;
        px = idx_reg[0] ? cur_reg.cx - u : cur_reg.cx + u;
        py = idx_reg[1] ? cur_reg.cy - v : cur_reg.cy + v;

        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (job_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (last_pt)
            begin
                cur_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
        if (take)
        begin
            x_reg     <= px;
            y_reg     <= py;
            color_reg <= cur_reg.color;
            last_reg  <= last_pt;
            done_reg  <= cur_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (load)
            begin
                out_valid_reg <= take;
            end
        end
    end

    assign pt_valid = out_valid_reg;
    assign pt_x     = x_reg;
    assign pt_y     = y_reg;
    assign pt_color = color_reg;
    assign pt_last  = last_reg;
    assign pt_done  = done_reg;

endmodule

### rtl/circle_point_generator_core.sv
// ============================================================================
// circle_point_generator_core - midpoint circle rasteriser
// Eight-way symmetric circle points, outline or filled, one point per cycle while the master accepts.
// ============================================================================
// Usage:
//   Slave channel: one transaction per item. tuser = 0 starts a circle from
//   the tdata fields and emits nothing; tuser = 1 advances one step, which
//   emits eight points while a circle runs and nothing otherwise.
//   Master channel: one transaction per point; tlast marks the eighth point
//   of a step, tuser flags every point of the step that ended the circle.
//   In outline mode a step walks one octant column, in filled mode one span
//   row from the current x up to the current y.
// Pipeline and throughput:
//   A step's points pass the job queue, the emitter's job register and the
//   output register. The emitter gives one point per cycle while the master
//   accepts; the two-entry job queue lets the input side take items in
//   back-to-back cycles until it fills.
// Reset and stall:
//   rst_n clears the walk, the queue pointers and the emitter's valid flags; no circle runs.
//   A stalled master holds the current point and, once the queue is full,
//   s_tready drops until the emitter frees an entry.
// ============================================================================
module circle_point_generator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] center_x, [15:8] center_y, [23:16] radius, [24] fill_flag,
    // [32:25] pen_color, [39:33] zero
    input  logic [cpg_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] point_x, [15:8] point_y, [23:16] point_color
    output logic [cpg_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,   // last_of_step
    // [0] circle_done
    output logic                           m_tuser
);
    import cpg_pkg::*;

    job_push_t          push;
    logic               q_valid;
    job_t               q_job;
    logic               q_pop;
    logic               s_fire;
    logic [COORD_W-1:0] pt_x, pt_y;
    logic [COLOR_W-1:0] pt_color;

    assign s_fire = s_tvalid && s_tready;

    // front end: decode items and advance the walk
    cpg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_fire   (s_fire),
        .item_mode   (s_tuser),
        .item_cx     (s_tdata[7:0]),
        .item_cy     (s_tdata[15:8]),
        .item_radius (s_tdata[23:16]),
        .item_fill   (s_tdata[24]),
        .item_color  (s_tdata[32:25]),
        .push        (push)
    );

    // job queue; its free space gates the slave channel
    cpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (s_tready),
        .pop_valid  (q_valid),
        .pop_job    (q_job),
        .pop        (q_pop)
    );

    // back end: eight points per job into the output register
    cpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .pt_valid  (m_tvalid),
        .pt_ready  (m_tready),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .pt_color  (pt_color),
        .pt_last   (m_tlast),
        .pt_done   (m_tuser)
    );

    assign m_tdata = {pt_color, pt_y, pt_x};

endmodule

### tb/circle_point_generator_core_tb.sv
// ============================================================================
// circle_point_generator_core_tb - self-checking bench for the circle core
// Drives start and step transactions on the slave stream and predicts every
// point of each step in a local midpoint-circle walk. The master stream is
// compared point by point against the predicted queue. Both sides pause at
// random in bursts, except in the closing back-to-back section.
// ============================================================================
`timescale 1ns / 1ps

module circle_point_generator_core_tb;

    import cpg_pkg::*;

    // one generated point as the master stream carries it
    typedef struct packed {
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] color;
        logic       last;
        logic       done;
    } point_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = MODE_START;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // local copy of the circle walk
    logic       walk_busy = 1'b0;
    logic [7:0] ctr_col   = '0;
    logic [7:0] ctr_row   = '0;
    logic [7:0] pen_held  = '0;
    logic       fill_held = 1'b0;
    int         walk_x    = 0;
    int         walk_y    = 0;
    int         row_y     = 0;
    int         walk_dec  = 0;

    point_t     point_q[$];        // points still owed by the core
    int         mismatch_count = 0;
    logic       tx_idle_en     = 1'b1;
    logic       rx_idle_en     = 1'b1;
    int         stall_left     = 0;

    circle_point_generator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // queue the eight symmetric points of the pair (a, b), in core order
    task automatic queue_octants(input int a, input int b, input logic done);
        int     dx[8];
        int     dy[8];
        point_t p;
        dx = '{a, -a, a, -a, b, -b, b, -b};
        dy = '{b, b, -b, -b, a, a, -a, -a};
        for (int k = 0; k < 8; k++)
        begin
            p.px    = 8'(int'(ctr_col) + dx[k]);
            p.py    = 8'(int'(ctr_row) + dy[k]);
            p.color = pen_held;
            p.last  = (k == 7);
            p.done  = done;
            point_q.push_back(p);
        end
    endtask

    task automatic step_walk();
        if (walk_dec < 0)
        begin
            walk_dec = walk_dec + 4 * walk_x + 6;
        end
        else
        begin
            walk_dec = walk_dec + 4 * (walk_x - walk_y) + 10;
            walk_y   = walk_y - 1;
        end
        walk_x = walk_x + 1;
    endtask

    task automatic predict_circle(input logic mode, input logic [S_DATA_W-1:0] data);
        int   a;
        int   b;
        logic done;
        if (mode == MODE_START)
        begin
            ctr_col   = data[7:0];
            ctr_row   = data[15:8];
            fill_held = data[24];
            pen_held  = data[32:25];
            walk_x    = 0;
            walk_y    = int'(data[23:16]);
            row_y     = 0;
            walk_dec  = 3 - 2 * int'(data[23:16]);
            walk_busy = 1'b1;
        end
        else if (walk_busy)
        begin
            if (fill_held)
            begin
                // filled: one span row per step, walk moves after the last row
                a     = walk_x;
                b     = row_y;
                row_y = row_y + 1;
                if (row_y > walk_y)
                begin
                    step_walk();
                    row_y = walk_x;
                end
            end
            else
            begin
                a = walk_x;
                b = walk_y;
                step_walk();
            end
            done = (walk_x > walk_y);
            queue_octants(a, b, done);
            if (done)
                walk_busy = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Slave side
    // ------------------------------------------------------------------------

    // one transaction; valid stays high afterwards unless the next call idles
    task automatic send_item(input logic mode, input logic [7:0] cx, input logic [7:0] cy,
                             input logic [7:0] rad, input logic fill, input logic [7:0] col);
        logic [S_DATA_W-1:0] data;
        data = {7'b0, col, fill, rad, cy, cx};
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_circle(mode, data);
    endtask

    task automatic send_start(input logic [7:0] cx, input logic [7:0] cy,
                              input logic [7:0] rad, input logic fill, input logic [7:0] col);
        send_item(MODE_START, cx, cy, rad, fill, col);
    endtask

    // step with junk in the data fields, which the core must ignore
    task automatic send_step();
        send_item(MODE_STEP, 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 8'($urandom));
    endtask

    // drop valid and wait until every owed point has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (point_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Master side: checker and random back-pressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : point_monitor
        point_t got;
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast, m_tuser};
            if (point_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected point x=%0d y=%0d c=%0d last=%0b done=%0b",
                             got.px, got.py, got.color, got.last, got.done);
            end
            else
            begin
                want = point_q.pop_front();
                if (got.px !== want.px || got.py !== want.py || got.color !== want.color
                    || got.last !== want.last || got.done !== want.done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("point mismatch: exp x=%0d y=%0d c=%0d last=%0b done=%0b,",
                                 want.px, want.py, want.color, want.last, want.done,
                                 " got x=%0d y=%0d c=%0d last=%0b done=%0b",
                                 got.px, got.py, got.color, got.last, got.done);
                end
            end
        end
        // ready: bursts of stall when enabled, otherwise always accepting
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // extremes, zero radius, restart while busy, idle steps
    task automatic test_directed();
        int guard;
        send_step();                                    // idle step: nothing
        send_start(8'd0, 8'd0, 8'd0, 1'b0, 8'd0);        // zero radius outline
        send_step();
        send_step();                                    // after done: nothing
        send_start(8'd255, 8'd255, 8'd0, 1'b1, 8'd255);  // zero radius filled
        send_step();
        send_start(8'd255, 8'd0, 8'd255, 1'b0, 8'hAA);   // largest radius, wraps
        repeat (3) send_step();
        send_start(8'd0, 8'd255, 8'd255, 1'b1, 8'h55);   // restart while busy
        repeat (3) send_step();
        send_start(8'd128, 8'd128, 8'd1, 1'b1, 8'h0F);   // small disc to the end
        guard = 0;
        while (walk_busy && guard < 8)
        begin
            send_step();
            guard++;
        end
        send_start(8'd3, 8'd250, 8'd3, 1'b0, 8'hF0);     // small outline to the end
        guard = 0;
        while (walk_busy && guard < 8)
        begin
            send_step();
            guard++;
        end
        drain();
    endtask

    // mostly well-formed circles with random content, some noise
    task automatic test_random_circles(input int n_items);
        int         sent;
        int         n_steps;
        int         pick;
        logic [7:0] rad;
        logic       fill;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // noise: a step that may land on an idle core
                send_step();
                if (walk_busy)
                    sent++;
                continue;
            end
            fill = 1'($urandom);
            pick = $urandom_range(0, 19);
            if (pick < 3)
                rad = 8'($urandom);                 // any radius, rarely finished
            else if (fill)
                rad = 8'($urandom_range(0, 5));
            else
                rad = 8'($urandom_range(0, 20));
            send_start(8'($urandom), 8'($urandom), rad, fill, 8'($urandom));
            sent++;
            n_steps = $urandom_range(1, 24);
            while (walk_busy && n_steps > 0)
            begin
                send_step();
                sent++;
                n_steps--;
            end
            if ($urandom_range(0, 3) == 0)
                send_step();                        // past the end or a cut walk
        end
        drain();
    endtask

    // closing section with neither side idling
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_circles(25);
    endtask

    initial
    begin : main_seq
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_circles(75);
        test_back_to_back();
        if (point_q.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
